/* hdl/ghm_pkg.sv */
// types and constants for the ghash gf(2^128) multiplier
// shared by the stage module, the top level and the checker; no dependencies
package ghm_pkg;

    // pipeline shape: stages times steps per stage covers all 128 multiplier bits
    localparam int GHM_BLOCK_W = 128;
    localparam int GHM_STEPS   = 8;
    localparam int GHM_STAGES  = GHM_BLOCK_W / GHM_STEPS;
    localparam int GHM_LATENCY = GHM_STAGES;

    // top byte of the reduction constant in reflected order (x^128 = 1 + x + x^2 + x^7)
    localparam logic [7:0] GHM_R_TOP = 8'hE1;

    typedef struct packed {
        logic [63:0] operand_a_high;
        logic [63:0] operand_a_low;
        logic [63:0] operand_b_high;
        logic [63:0] operand_b_low;
    } t_operands;

    typedef struct packed {
        logic [63:0] product_high;
        logic [63:0] product_low;
    } t_product;

    // working set carried down the pipeline
    typedef struct packed {
        logic [GHM_BLOCK_W-1:0] x;  // multiplier, next bit to use at the top
        logic [GHM_BLOCK_W-1:0] v;  // multiplicand times x^k
        logic [GHM_BLOCK_W-1:0] z;  // partial product
    } t_lane;

endpackage

/* hdl/ghm_stage.sv */
// one pipeline stage of the ghash multiplier: GHM_STEPS shift-and-xor steps, then a register
// depends on ghm_pkg
module ghm_stage
    import ghm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_lane i_lane,
    output logic  o_valid,
    output t_lane o_lane
);

    logic  r_valid;
    t_lane r_lane;
    t_lane n_lane;

    always_comb begin
        logic lsb;
        n_lane = i_lane;
        for (int k = 0; k < GHM_STEPS; k++) begin
            if (n_lane.x[GHM_BLOCK_W-1]) begin
                n_lane.z = n_lane.z ^ n_lane.v;
            end
            lsb      = n_lane.v[0];
            n_lane.v = n_lane.v >> 1;
            if (lsb) begin
                n_lane.v[GHM_BLOCK_W-1 -: 8] = n_lane.v[GHM_BLOCK_W-1 -: 8] ^ GHM_R_TOP;
            end
            n_lane.x = n_lane.x << 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lane <= n_lane;
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

/* hdl/ghash_gf128_multiplier.sv */
// ghash gf(2^128) multiplier, result strobe registered through every stage after acceptance
// one transfer accepted every cycle, busy is never raised
// the rate is set by the 16-stage shift-and-xor pipeline, 8 multiplier bits per stage
// synchronous active-low reset clears the stage valid bits; data registers are not reset
// depends on ghm_pkg and ghm_stage
module ghash_gf128_multiplier
    import ghm_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_operands i_operands,
    output logic      o_valid,
    output t_product  o_result
);

    logic  w_valid [GHM_STAGES+1];
    t_lane w_lane  [GHM_STAGES+1];

    assign busy       = 1'b0;
    assign w_valid[0] = start && !busy;
    assign w_lane[0]  = '{x: {i_operands.operand_a_high, i_operands.operand_a_low},
                          v: {i_operands.operand_b_high, i_operands.operand_b_low},
                          z: '0};

    for (genvar s = 0; s < GHM_STAGES; s++) begin : g_stage
        ghm_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[s]),
            .i_lane  (w_lane[s]),
            .o_valid (w_valid[s+1]),
            .o_lane  (w_lane[s+1])
        );
    end

    assign o_valid               = w_valid[GHM_STAGES];
    assign o_result.product_high = w_lane[GHM_STAGES].z[GHM_BLOCK_W-1 -: 64];
    assign o_result.product_low  = w_lane[GHM_STAGES].z[63:0];

endmodule

/* hdl/ghm_checker.sv */
// port-level checks for the ghash multiplier, bound to the top level
// depends on ghm_pkg and ghash_gf128_multiplier
module ghm_checker
    import ghm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_operands i_operands,
    input logic      o_valid,
    input t_product  o_result
);

    // the pipeline always takes a transfer
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    // every accepted transfer comes out as a result strobe at the end of the pipeline
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(GHM_LATENCY) o_valid)
        else $error("result strobe missing");

    // no strobe without a transfer accepted at the pipeline input
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, GHM_LATENCY))
        else $error("result strobe without a transfer");

    // zero multiplier gives zero product
    a_zero_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(start && !busy && i_operands.operand_a_high == 64'd0
                          && i_operands.operand_a_low == 64'd0, GHM_LATENCY))
        |-> (o_result.product_high == 64'd0 && o_result.product_low == 64'd0))
        else $error("nonzero product for zero operand");

endmodule

bind ghash_gf128_multiplier ghm_checker u_ghm_checker (.*);
